/* rtl/core/tkms_pkg.sv */
// ----------------------------------------------------------------------------
// tkms_pkg: shared types and constants of the top-K most recent selector
// Slot store geometry, field widths, register map, scan interface structs
// and the controller state encoding.
// ----------------------------------------------------------------------------
package tkms_pkg;

  // Number of slots in the store.
  localparam int KEEP_COUNT   = 64;
  localparam int SLOT_AW      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int FILL_W       = $clog2(KEEP_COUNT + 1);

  // Field widths.
  localparam int ID_W         = 16;
  localparam int STAMP_W      = 63;
  localparam int RANK_W       = 6;
  localparam int CNT_W        = 7;
  localparam int CMP_W        = (FILL_W > CNT_W) ? FILL_W : CNT_W;

  // Report count handling.
  localparam int REPORT_LIMIT = 64;
  localparam int REPORT_RESET = 10;

  // Configuration port.
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam logic REG_REPORT_COUNT = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  // Scan request from the controller to the scan unit.
  typedef struct packed {
    logic               start;
    logic               mode_next;   // 1: next in newest-first order, 0: oldest slot
    logic               first;       // first rank of a report, no predecessor
    logic [FILL_W-1:0]  count;       // number of slots to visit, at least 1
    logic [STAMP_W-1:0] prev_stamp;
    logic [SLOT_AW-1:0] prev_idx;
  } scan_req_t;

  // Scan result back to the controller.
  typedef struct packed {
    logic               done;
    logic [SLOT_AW-1:0] idx;
    slot_t              slot;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND_OLD,
    ST_FIND_NEXT,
    ST_EMIT
  } state_t;

endpackage

/* rtl/core/tkms_slot_mem.sv */
// ----------------------------------------------------------------------------
// tkms_slot_mem: slot store
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module tkms_slot_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [tkms_pkg::SLOT_AW-1:0] wr_addr,
  input  tkms_pkg::slot_t             wr_data,
  input  logic                        rd_en,
  input  logic [tkms_pkg::SLOT_AW-1:0] rd_addr,
  output tkms_pkg::slot_t             rd_data
);

  tkms_pkg::slot_t mem_r [tkms_pkg::KEEP_COUNT];
  tkms_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/tkms_scan.sv */
// ----------------------------------------------------------------------------
// tkms_scan: slot scan unit
// Walks the occupied slots one per cycle through the memory read port and
// keeps the best candidate: either the first-indexed oldest slot, or the
// next slot in newest-first order after a given predecessor.
// ----------------------------------------------------------------------------
module tkms_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tkms_pkg::scan_req_t          req,
  output logic                         rd_en,
  output logic [tkms_pkg::SLOT_AW-1:0] rd_addr,
  input  tkms_pkg::slot_t              rd_data,
  output tkms_pkg::scan_res_t          res
);

  logic                                issue_r;
  logic                                chk_v_r;
  logic                                chk_last_r;
  logic                                done_r;
  logic                                found_r;
  logic [tkms_pkg::SLOT_AW-1:0]        addr_r;
  logic [tkms_pkg::SLOT_AW-1:0]        last_addr_r;
  logic [tkms_pkg::SLOT_AW-1:0]        chk_idx_r;
  logic [tkms_pkg::SLOT_AW-1:0]        best_idx_r;
  tkms_pkg::slot_t                     best_r;
  logic                                mode_next_r;
  logic                                first_r;
  logic [tkms_pkg::STAMP_W-1:0]        prev_stamp_r;
  logic [tkms_pkg::SLOT_AW-1:0]        prev_idx_r;
  logic [tkms_pkg::FILL_W-1:0]         last_cnt;
  logic                                eligible;
  logic                                better;
  logic                                take;

  assign last_cnt = req.count - tkms_pkg::FILL_W'(1);

  // In newest-first mode a slot follows the predecessor if it is older, or
  // equally old and at a higher index. Scanning upward with strict compares
  // keeps the lowest index among equal stamps.
  always_comb begin
    eligible = !mode_next_r || first_r ||
               (rd_data.stamp < prev_stamp_r) ||
               ((rd_data.stamp == prev_stamp_r) && (chk_idx_r > prev_idx_r));
    if (mode_next_r) begin
      better = !found_r || (rd_data.stamp > best_r.stamp);
    end else begin
      better = !found_r || (rd_data.stamp < best_r.stamp);
    end
    take = chk_v_r && eligible && better;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      chk_v_r <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      chk_v_r <= issue_r;
      done_r  <= chk_v_r && chk_last_r;
      if (req.start) begin
        issue_r <= 1'b1;
        found_r <= 1'b0;
      end else begin
        if (issue_r && (addr_r == last_addr_r)) begin
          issue_r <= 1'b0;
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= addr_r;
    chk_last_r <= (addr_r == last_addr_r);
    if (req.start) begin
      addr_r       <= '0;
      last_addr_r  <= last_cnt[tkms_pkg::SLOT_AW-1:0];
      mode_next_r  <= req.mode_next;
      first_r      <= req.first;
      prev_stamp_r <= req.prev_stamp;
      prev_idx_r   <= req.prev_idx;
    end else if (issue_r) begin
      addr_r <= addr_r + tkms_pkg::SLOT_AW'(1);
    end
    if (take) begin
      best_r     <= rd_data;
      best_idx_r <= chk_idx_r;
    end
  end

  assign rd_en    = issue_r;
  assign rd_addr  = addr_r;
  assign res.done = done_r;
  assign res.idx  = best_idx_r;
  assign res.slot = best_r;

endmodule

/* rtl/core/tkms_ctrl.sv */
// ----------------------------------------------------------------------------
// tkms_ctrl: sequencer of the selector
// Accepts items, fills free slots, runs replacement and ranking scans,
// writes the store and holds the result output register.
// ----------------------------------------------------------------------------
module tkms_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tkms_pkg::ID_W-1:0]    in_entry_id,
  input  logic [tkms_pkg::STAMP_W-1:0] in_stamp,
  input  logic                         in_end_of_list,
  input  logic [tkms_pkg::CNT_W-1:0]   report_count,
  output tkms_pkg::scan_req_t          scan_req,
  input  tkms_pkg::scan_res_t          scan_res,
  output logic                         wr_en,
  output logic [tkms_pkg::SLOT_AW-1:0] wr_addr,
  output tkms_pkg::slot_t              wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tkms_pkg::ID_W-1:0]    out_id,
  output logic [tkms_pkg::STAMP_W-1:0] out_stamp,
  output logic [tkms_pkg::RANK_W-1:0]  out_rank,
  output logic                         out_none_found,
  output logic                         out_last
);

  tkms_pkg::state_t                  state_r;
  tkms_pkg::state_t                  state_nxt;
  logic [tkms_pkg::FILL_W-1:0]       fill_r;
  logic [tkms_pkg::CNT_W-1:0]        lim_r;
  logic [tkms_pkg::CNT_W-1:0]        rank_r;
  logic                              none_r;
  tkms_pkg::slot_t                   item_r;
  tkms_pkg::slot_t                   res_r;
  logic [tkms_pkg::SLOT_AW-1:0]      res_idx_r;
  logic                              out_valid_r;
  tkms_pkg::slot_t                   out_slot_r;
  logic [tkms_pkg::RANK_W-1:0]       out_rank_r;
  logic                              out_none_r;
  logic                              out_last_r;

  logic                              accept;
  logic                              full;
  logic                              empty;
  logic                              out_load;
  logic                              emit_last;
  logic [tkms_pkg::CNT_W-1:0]        rc_eff;
  logic [tkms_pkg::CNT_W-1:0]        lim_calc;

  assign accept    = in_valid && (state_r == tkms_pkg::ST_IDLE);
  assign full      = (fill_r == tkms_pkg::FILL_W'(tkms_pkg::KEEP_COUNT));
  assign empty     = (fill_r == '0);
  assign emit_last = none_r || ((rank_r + tkms_pkg::CNT_W'(1)) == lim_r);
  assign out_load  = (state_r == tkms_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  // A report count of zero counts as one and is capped at the report limit,
  // then limited to the number of entries held.
  always_comb begin
    if (report_count == '0) begin
      rc_eff = tkms_pkg::CNT_W'(1);
    end else if (report_count > tkms_pkg::CNT_W'(tkms_pkg::REPORT_LIMIT)) begin
      rc_eff = tkms_pkg::CNT_W'(tkms_pkg::REPORT_LIMIT);
    end else begin
      rc_eff = report_count;
    end
    if (tkms_pkg::CMP_W'(fill_r) < tkms_pkg::CMP_W'(rc_eff)) begin
      lim_calc = tkms_pkg::CNT_W'(fill_r);
    end else begin
      lim_calc = rc_eff;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tkms_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_end_of_list) begin
            state_nxt = empty ? tkms_pkg::ST_EMIT : tkms_pkg::ST_FIND_NEXT;
          end else if (full) begin
            state_nxt = tkms_pkg::ST_FIND_OLD;
          end
        end
      end
      tkms_pkg::ST_FIND_OLD: begin
        if (scan_res.done) begin
          state_nxt = tkms_pkg::ST_IDLE;
        end
      end
      tkms_pkg::ST_FIND_NEXT: begin
        if (scan_res.done) begin
          state_nxt = tkms_pkg::ST_EMIT;
        end
      end
      tkms_pkg::ST_EMIT: begin
        if (out_load) begin
          state_nxt = emit_last ? tkms_pkg::ST_IDLE : tkms_pkg::ST_FIND_NEXT;
        end
      end
      default: state_nxt = tkms_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the scan unit and the store.
  always_comb begin
    in_ready            = (state_r == tkms_pkg::ST_IDLE);
    scan_req.start      = 1'b0;
    scan_req.mode_next  = 1'b0;
    scan_req.first      = 1'b0;
    scan_req.count      = fill_r;
    scan_req.prev_stamp = res_r.stamp;
    scan_req.prev_idx   = res_idx_r;
    wr_en               = 1'b0;
    wr_addr             = fill_r[tkms_pkg::SLOT_AW-1:0];
    wr_data.id          = in_entry_id;
    wr_data.stamp       = in_stamp;
    unique case (state_r)
      tkms_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_end_of_list) begin
            scan_req.start     = !empty;
            scan_req.mode_next = 1'b1;
            scan_req.first     = 1'b1;
          end else if (full) begin
            scan_req.start = 1'b1;
            scan_req.count = tkms_pkg::FILL_W'(tkms_pkg::KEEP_COUNT);
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      tkms_pkg::ST_FIND_OLD: begin
        // Replace the oldest slot only with a strictly newer item.
        if (scan_res.done && (item_r.stamp > scan_res.slot.stamp)) begin
          wr_en   = 1'b1;
          wr_addr = scan_res.idx;
          wr_data = item_r;
        end
      end
      tkms_pkg::ST_FIND_NEXT: begin
      end
      tkms_pkg::ST_EMIT: begin
        if (out_load && !emit_last) begin
          scan_req.start     = 1'b1;
          scan_req.mode_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkms_pkg::ST_IDLE;
      fill_r      <= '0;
      none_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && !in_end_of_list && !full) begin
        fill_r <= fill_r + tkms_pkg::FILL_W'(1);
      end else if (out_load && emit_last) begin
        fill_r <= '0;
      end
      if (accept && in_end_of_list && empty) begin
        none_r <= 1'b1;
      end else if (out_load) begin
        none_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.id    <= in_entry_id;
      item_r.stamp <= in_stamp;
      lim_r        <= lim_calc;
      rank_r       <= '0;
    end else if (out_load) begin
      rank_r <= rank_r + tkms_pkg::CNT_W'(1);
    end
    if ((state_r == tkms_pkg::ST_FIND_NEXT) && scan_res.done) begin
      res_r     <= scan_res.slot;
      res_idx_r <= scan_res.idx;
    end
    if (out_load) begin
      out_last_r <= emit_last;
      out_none_r <= none_r;
      if (none_r) begin
        out_slot_r <= '0;
        out_rank_r <= '0;
      end else begin
        out_slot_r <= res_r;
        out_rank_r <= rank_r[tkms_pkg::RANK_W-1:0];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_id         = out_slot_r.id;
  assign out_stamp      = out_slot_r.stamp;
  assign out_rank       = out_rank_r;
  assign out_none_found = out_none_r;
  assign out_last       = out_last_r;

endmodule

/* rtl/core/top_k_most_recent_selector.sv */
// ----------------------------------------------------------------------------
// top_k_most_recent_selector: keeps the newest entries of a list
// Top level: configuration register, slot store, scan unit and sequencer.
// ----------------------------------------------------------------------------
// The block keeps the 64 newest (entry_id, stamp) items of a list in a slot
// memory and, on an end marker, reports them newest first (equal stamps in
// slot order), up to the configured report count, marking the final result
// with last; an empty list gives a single none_found result. Once the store
// is full, the scan unit reads every slot through the single memory read port
// to find the oldest one for each item. For an end marker, each rank is found
// by a fresh pass over the occupied slots. Results leave through an output
// register; a waiting result that is not taken stalls the next scan step.
// There is no clearing pass after reset; the store is only read where written.
module top_k_most_recent_selector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tkms_pkg::ID_W-1:0]    in_entry_id,
  input  logic [tkms_pkg::STAMP_W-1:0] in_stamp,
  input  logic                         in_end_of_list,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tkms_pkg::ID_W-1:0]    out_id,
  output logic [tkms_pkg::STAMP_W-1:0] out_stamp,
  output logic [tkms_pkg::RANK_W-1:0]  out_rank,
  output logic                         out_none_found,
  output logic                         out_last,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tkms_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tkms_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tkms_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  logic [tkms_pkg::CNT_W-1:0]   report_count_r;
  logic                         cfg_wr;
  tkms_pkg::scan_req_t          scan_req;
  tkms_pkg::scan_res_t          scan_res;
  logic                         wr_en;
  logic [tkms_pkg::SLOT_AW-1:0] wr_addr;
  tkms_pkg::slot_t              wr_data;
  logic                         rd_en;
  logic [tkms_pkg::SLOT_AW-1:0] rd_addr;
  tkms_pkg::slot_t              rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_count_r <= tkms_pkg::CNT_W'(tkms_pkg::REPORT_RESET);
    end else if (cfg_wr && (cfg_paddr[2] == tkms_pkg::REG_REPORT_COUNT)) begin
      report_count_r <= cfg_pwdata[tkms_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == tkms_pkg::REG_REPORT_COUNT) begin
      cfg_prdata = tkms_pkg::CFG_DW'(report_count_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  tkms_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tkms_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (scan_req),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (scan_res)
  );

  tkms_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_entry_id    (in_entry_id),
    .in_stamp       (in_stamp),
    .in_end_of_list (in_end_of_list),
    .report_count   (report_count_r),
    .scan_req       (scan_req),
    .scan_res       (scan_res),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_id         (out_id),
    .out_stamp      (out_stamp),
    .out_rank       (out_rank),
    .out_none_found (out_none_found),
    .out_last       (out_last)
  );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the top-K most recent selector
// Sends lists of (entry id, stamp) items closed by end markers, programs the
// report count between lists over the APB port, and checks every ranked
// result against a behavioral model of the slot store, kept in step with each
// accepted input transfer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS   = 410;
  localparam int STALL_LIMIT   = 1500;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT      = 19;
  localparam int CALM_FIRST    = 150;
  localparam int CALM_LAST     = 250;

  localparam logic [tkms_pkg::STAMP_W-1:0] STAMP_MAX = {tkms_pkg::STAMP_W{1'b1}};
  localparam logic [tkms_pkg::CFG_AW-1:0]  ADDR_REPORT_COUNT =
    tkms_pkg::CFG_AW'(tkms_pkg::REG_REPORT_COUNT) << 2;
  localparam logic [tkms_pkg::CFG_AW-1:0]  ADDR_UNMAPPED =
    ADDR_REPORT_COUNT + tkms_pkg::CFG_AW'(4);

  typedef struct packed {
    logic [tkms_pkg::ID_W-1:0]    id;
    logic [tkms_pkg::STAMP_W-1:0] stamp;
    logic [tkms_pkg::RANK_W-1:0]  rank;
    logic                         none_found;
    logic                         last;
  } ranked_t;

  typedef enum logic [1:0] {
    ROW_ENTRY,
    ROW_END,
    ROW_CFG
  } plan_kind_t;

  typedef struct {
    plan_kind_t                   kind;
    logic [tkms_pkg::ID_W-1:0]    id;
    logic [tkms_pkg::STAMP_W-1:0] stamp;
    logic [tkms_pkg::CFG_AW-1:0]  addr;
    logic [tkms_pkg::CFG_DW-1:0]  data;
    bit                           typed;
    ranked_t                      want;
  } plan_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [tkms_pkg::ID_W-1:0]    in_entry_id;
  logic [tkms_pkg::STAMP_W-1:0] in_stamp;
  logic                         in_end_of_list;
  logic                         out_valid;
  logic                         out_ready;
  logic [tkms_pkg::ID_W-1:0]    out_id;
  logic [tkms_pkg::STAMP_W-1:0] out_stamp;
  logic [tkms_pkg::RANK_W-1:0]  out_rank;
  logic                         out_none_found;
  logic                         out_last;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [tkms_pkg::CFG_AW-1:0]  cfg_paddr;
  logic [tkms_pkg::CFG_DW-1:0]  cfg_pwdata;
  logic [tkms_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                         cfg_pready;

  // Model of the slot store and the report count register.
  bit [tkms_pkg::ID_W-1:0]    model_ids[tkms_pkg::KEEP_COUNT];
  bit [tkms_pkg::STAMP_W-1:0] model_stamps[tkms_pkg::KEEP_COUNT];
  int                         model_held;
  bit [tkms_pkg::CNT_W-1:0]   model_report_count;

  ranked_t ranking_q[$];
  int      fails;
  int      items_sent;
  int      quiet_cycles;
  bit      calm;

  top_k_most_recent_selector u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_entry_id    (in_entry_id),
    .in_stamp       (in_stamp),
    .in_end_of_list (in_end_of_list),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_id         (out_id),
    .out_stamp      (out_stamp),
    .out_rank       (out_rank),
    .out_none_found (out_none_found),
    .out_last       (out_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Updates the store model with one accepted item and queues the ranking that
  // an end marker produces. Returns the number of results queued.
  function automatic int rank_store(input bit eol, input bit [tkms_pkg::ID_W-1:0] id,
                                    input bit [tkms_pkg::STAMP_W-1:0] st);
    int      oldest;
    int      lim;
    int      pick;
    int      i;
    int      k;
    bit      taken[tkms_pkg::KEEP_COUNT];
    ranked_t r;
    if (!eol) begin
      if (model_held < tkms_pkg::KEEP_COUNT) begin
        model_ids[model_held]    = id;
        model_stamps[model_held] = st;
        model_held++;
      end else begin
        oldest = 0;
        for (i = 1; i < tkms_pkg::KEEP_COUNT; i++) begin
          if (model_stamps[i] < model_stamps[oldest]) oldest = i;
        end
        if (st > model_stamps[oldest]) begin
          model_ids[oldest]    = id;
          model_stamps[oldest] = st;
        end
      end
      return 0;
    end
    if (model_held == 0) begin
      r            = '0;
      r.none_found = 1'b1;
      r.last       = 1'b1;
      ranking_q.push_back(r);
      return 1;
    end
    lim = int'(model_report_count);
    if (lim < 1) lim = 1;
    if (lim > tkms_pkg::REPORT_LIMIT) lim = tkms_pkg::REPORT_LIMIT;
    if (lim > model_held) lim = model_held;
    // Repeatedly take the newest untaken slot; the lowest index wins a tie.
    for (k = 0; k < lim; k++) begin
      pick = -1;
      for (i = 0; i < model_held; i++) begin
        if (!taken[i] && (pick < 0 || model_stamps[i] > model_stamps[pick])) pick = i;
      end
      taken[pick]  = 1'b1;
      r.id         = model_ids[pick];
      r.stamp      = model_stamps[pick];
      r.rank       = tkms_pkg::RANK_W'(k);
      r.none_found = 1'b0;
      r.last       = (k == lim - 1);
      ranking_q.push_back(r);
    end
    model_held = 0;
    return lim;
  endfunction

  function automatic plan_row_t entry_row(input logic [tkms_pkg::ID_W-1:0] id,
                                          input logic [tkms_pkg::STAMP_W-1:0] st);
    plan_row_t r;
    r.kind  = ROW_ENTRY;
    r.id    = id;
    r.stamp = st;
    r.addr  = '0;
    r.data  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic plan_row_t end_row(input bit typed, input ranked_t want);
    plan_row_t r;
    r       = entry_row('0, '0);
    r.kind  = ROW_END;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [tkms_pkg::CFG_AW-1:0] addr,
                                        input logic [tkms_pkg::CFG_DW-1:0] data);
    plan_row_t r;
    r      = entry_row('0, '0);
    r.kind = ROW_CFG;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  // The payload of an end marker is don't-care, so it carries random bits.
  task automatic send_item(input bit eol, input logic [tkms_pkg::ID_W-1:0] id,
                           input logic [tkms_pkg::STAMP_W-1:0] st, input bit typed,
                           input ranked_t want);
    int n;
    calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_end_of_list <= eol;
    in_entry_id    <= eol ? tkms_pkg::ID_W'($urandom) : id;
    in_stamp       <= eol ? tkms_pkg::STAMP_W'({$urandom, $urandom}) : st;
    do @(posedge clk); while (!in_ready);
    n = rank_store(eol, id, st);
    if (typed) begin
      repeat (n) void'(ranking_q.pop_back());
      ranking_q.push_back(want);
    end
    items_sent++;
  endtask

  // Register writes only happen with the block idle and every result collected.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (ranking_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [tkms_pkg::CFG_AW-1:0] addr,
                           input logic [tkms_pkg::CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_REPORT_COUNT) model_report_count = data[tkms_pkg::CNT_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [tkms_pkg::STAMP_W-1:0] pick_stamp(
      input int mode, input int pos, input logic [tkms_pkg::STAMP_W-1:0] base);
    case (mode)
      0: return tkms_pkg::STAMP_W'({$urandom, $urandom});
      1: return tkms_pkg::STAMP_W'($urandom_range(15));
      2: return base + tkms_pkg::STAMP_W'(3 * pos);
      default: begin
        case ($urandom_range(3))
          0: return '0;
          1: return STAMP_MAX;
          2: return STAMP_MAX - 1;
          default: return tkms_pkg::STAMP_W'({$urandom, $urandom});
        endcase
      end
    endcase
  endfunction

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk) begin
    ranked_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (ranking_q.size() == 0) begin
          $error("result with no expectation: id=%h stamp=%h rank=%0d", out_id, out_stamp,
                 out_rank);
          fails++;
        end else begin
          want = ranking_q.pop_front();
          if (out_id !== want.id) begin
            $error("out_id: expected %h, got %h", want.id, out_id);
            fails++;
          end
          if (out_stamp !== want.stamp) begin
            $error("out_stamp: expected %h, got %h", want.stamp, out_stamp);
            fails++;
          end
          if (out_rank !== want.rank) begin
            $error("out_rank: expected %0d, got %0d", want.rank, out_rank);
            fails++;
          end
          if (out_none_found !== want.none_found) begin
            $error("out_none_found: expected %b, got %b", want.none_found, out_none_found);
            fails++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, out_last);
            fails++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[top_k_most_recent_selector] ERROR");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t                    plan[$];
    int                           list_no;
    int                           len;
    int                           mode;
    int                           j;
    int                           r;
    logic [tkms_pkg::ID_W-1:0]    id;
    logic [tkms_pkg::STAMP_W-1:0] base;

    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_entry_id        = '0;
    in_stamp           = '0;
    in_end_of_list     = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    items_sent         = 0;
    calm               = 1'b0;
    model_held         = 0;
    model_report_count = tkms_pkg::CNT_W'(tkms_pkg::REPORT_RESET);

    // Empty lists, single entries at the field extremes, equal stamps,
    // report count of zero, an unmapped register, report count above the limit.
    plan.push_back(end_row(1'b1, ranked_t'({tkms_pkg::ID_W'(0), tkms_pkg::STAMP_W'(0),
                                            tkms_pkg::RANK_W'(0), 1'b1, 1'b1})));
    plan.push_back(end_row(1'b1, ranked_t'({tkms_pkg::ID_W'(0), tkms_pkg::STAMP_W'(0),
                                            tkms_pkg::RANK_W'(0), 1'b1, 1'b1})));
    plan.push_back(entry_row(16'hFFFF, STAMP_MAX));
    plan.push_back(end_row(1'b1, ranked_t'({tkms_pkg::ID_W'(16'hFFFF), STAMP_MAX,
                                            tkms_pkg::RANK_W'(0), 1'b0, 1'b1})));
    plan.push_back(entry_row(16'h0000, '0));
    plan.push_back(end_row(1'b1, ranked_t'({tkms_pkg::ID_W'(0), tkms_pkg::STAMP_W'(0),
                                            tkms_pkg::RANK_W'(0), 1'b0, 1'b1})));
    plan.push_back(entry_row(16'd1, tkms_pkg::STAMP_W'(5)));
    plan.push_back(entry_row(16'd2, tkms_pkg::STAMP_W'(7)));
    plan.push_back(entry_row(16'd3, tkms_pkg::STAMP_W'(5)));
    plan.push_back(entry_row(16'd4, tkms_pkg::STAMP_W'(7)));
    plan.push_back(end_row(1'b0, '0));
    plan.push_back(cfg_row(ADDR_REPORT_COUNT, 32'd0));
    plan.push_back(entry_row(16'd5, tkms_pkg::STAMP_W'(100)));
    plan.push_back(entry_row(16'd6, tkms_pkg::STAMP_W'(200)));
    plan.push_back(end_row(1'b0, '0));
    plan.push_back(cfg_row(ADDR_UNMAPPED, 32'd3));
    plan.push_back(entry_row(16'd7, tkms_pkg::STAMP_W'(1)));
    plan.push_back(entry_row(16'd8, tkms_pkg::STAMP_W'(2)));
    plan.push_back(end_row(1'b0, '0));
    plan.push_back(cfg_row(ADDR_REPORT_COUNT, 32'd127));
    plan.push_back(entry_row(16'd9, STAMP_MAX - 1));
    plan.push_back(entry_row(16'd10, STAMP_MAX));
    plan.push_back(entry_row(16'd11, '0));
    plan.push_back(end_row(1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_ENTRY: send_item(1'b0, plan[i].id, plan[i].stamp, 1'b0, '0);
        ROW_END:   send_item(1'b1, '0, '0, plan[i].typed, plan[i].want);
        default: begin
          drain_and_settle();
          cfg_write(plan[i].addr, plan[i].data);
        end
      endcase
    end

    // Random lists. The first one overfills the store with the report count
    // saturated, so every rank shows up.
    list_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (list_no > 0 && $urandom_range(99) < 35) begin
        drain_and_settle();
        case ($urandom_range(7))
          0: cfg_write(ADDR_REPORT_COUNT, 32'd0);
          1: cfg_write(ADDR_REPORT_COUNT, 32'd1);
          2: cfg_write(ADDR_REPORT_COUNT, 32'd64);
          3: cfg_write(ADDR_REPORT_COUNT, 32'd127);
          4: cfg_write(ADDR_REPORT_COUNT, 32'd65);
          5: cfg_write(ADDR_REPORT_COUNT, tkms_pkg::CFG_DW'({$urandom, 7'd0}) |
                                          tkms_pkg::CFG_DW'($urandom_range(1, 64)));
          6: cfg_write(ADDR_UNMAPPED, $urandom);
          default: cfg_write(ADDR_REPORT_COUNT, $urandom);
        endcase
      end
      r = $urandom_range(99);
      if (list_no == 0) len = 72;
      else if (r < 35) len = $urandom_range(4);
      else if (r < 75) len = $urandom_range(5, 30);
      else len = $urandom_range(60, 90);
      // The end marker counts as an item too.
      if (len > TOTAL_ITEMS - items_sent - 1) len = TOTAL_ITEMS - items_sent - 1;
      mode = (list_no == 0) ? 2 : $urandom_range(3);
      base = tkms_pkg::STAMP_W'({$urandom, $urandom}) >> 1;
      for (j = 0; j < len; j++) begin
        if ($urandom_range(3) == 0) id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else id = tkms_pkg::ID_W'($urandom);
        send_item(1'b0, id, pick_stamp(mode, j, base), 1'b0, '0);
      end
      send_item(1'b1, '0, '0, 1'b0, '0);
      list_no++;
    end

    drain_and_settle();
    if (fails == 0) begin
      $display("[top_k_most_recent_selector] OK");
    end else begin
      $display("[top_k_most_recent_selector] ERROR");
    end
    $finish;
  end

endmodule
